### rtl/lstc_pkg.sv
// Shared types, constants and cosine table functions for the lidar sector TTC monitor.
`default_nettype none

package lstc_pkg;

   // Default sizes
   localparam int MAX_BEAMS_DEFAULT   = 4096;
   localparam int COS_ENTRIES_DEFAULT = 1024;
   localparam int Q_DEPTH             = 4;
   localparam int Q_PTR_W             = $clog2(Q_DEPTH);
   localparam int Q_CNT_W             = $clog2(Q_DEPTH + 1);

   // Operation codes
   localparam logic [1:0] OP_SPEED = 2'd0;
   localparam logic [1:0] OP_STEER = 2'd1;
   localparam logic [1:0] OP_BEAM  = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_FLOOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_CEILING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_START   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_WINDOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSING_FLOOR = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_RANGE_FLOOR   = 16'd60;
   localparam logic [15:0] RST_RANGE_CEILING = 16'd30000;
   localparam logic [15:0] RST_ANGLE_START   = 16'hA061;
   localparam logic [11:0] RST_ANGLE_STEP    = 12'd45;
   localparam logic [14:0] RST_ANGLE_WINDOW  = 15'd4172;
   localparam logic [15:0] RST_CLOSING_FLOOR = 16'd1;

   // 1000 ms/s times Q14 one
   localparam logic [23:0] TTC_SCALE = 24'd16384000;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] speed_mm_s;
      logic signed [15:0] steer_angle;
      logic [15:0]        beam_range_mm;
      logic               range_is_number;
      logic               last_beam;
   } req_type;

   typedef struct packed {
      logic [15:0] min_distance_mm;
      logic        distance_found;
      logic [15:0] min_ttc_ms;
      logic        ttc_found;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        range_floor_mm;
      logic [15:0]        range_ceiling_mm;
      logic signed [15:0] angle_start;
      logic [11:0]        angle_step;
      logic [14:0]        angle_window;
      logic [15:0]        closing_floor_mm_s;
   } cfg_type;

   // One classified beam handed from front to back
   typedef struct packed {
      logic        keep;
      logic        last;
      logic [15:0] range;
      logic [16:0] speed;
      logic [15:0] angle;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Q14 cosine over the first quadrant, r in quarter-turn units of 2^-14
   function automatic longint quarter_cos(input longint r);
      longint x;
      longint x2;
      longint t;
      longint p;
      int     i;
      x = (r * HALF_PI_Q30) >>> 14;
      x2 = (x * x) >>> 30;
      t = Q30_ONE;
      for (i = 0; i < 6; i++) begin
         p = (x2 * t) >>> 30;
         case (i)
            0:       t = Q30_ONE - p / 132;
            1:       t = Q30_ONE - p / 90;
            2:       t = Q30_ONE - p / 56;
            3:       t = Q30_ONE - p / 30;
            4:       t = Q30_ONE - p / 12;
            default: t = Q30_ONE - p / 2;
         endcase
         if (t < 0) t = 0;
         if (t > Q30_ONE) t = Q30_ONE;
      end
      return (t + 32768) >>> 16;
   endfunction

   // Table entry k for a table of 2^idx_w entries
   function automatic logic signed [15:0] cos_entry(input int k, input int idx_w);
      longint a;
      longint q;
      longint r;
      longint v;
      a = (longint'(k) << (16 - idx_w)) & 64'sh0000_FFFF;
      q = a >>> 14;
      r = a & 64'sh0000_3FFF;
      case (q)
         0:       v = quarter_cos(r);
         1:       v = -quarter_cos(16384 - r);
         2:       v = -quarter_cos(r);
         default: v = quarter_cos(16384 - r);
      endcase
      return 16'(v);
   endfunction

endpackage

`default_nettype wire

### rtl/lstc_front.sv
// Front end: accepts items, tracks speed, steering and beam index, classifies beams.
`default_nettype none

module lstc_front import lstc_pkg::*; #(
   parameter int MAX_BEAMS = MAX_BEAMS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   input  wire q_status_type q_status,
   output logic         push,
   output job_type      push_data
);

   localparam int CNT_W = $clog2(MAX_BEAMS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BEAMS - 1);

   localparam logic F_IDLE = 1'b0;
   localparam logic F_BEAM = 1'b1;

   logic              state_ff, state_in;
   logic [16:0]       held_speed_ff, held_speed_in;
   logic [15:0]       held_steer_ff, held_steer_in;
   logic [16:0]       scan_speed_ff, scan_speed_in;
   logic [15:0]       scan_steer_ff, scan_steer_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       angle_ff, angle_in;
   logic              rng_ok_ff, rng_ok_in;
   logic [15:0]       range_ff, range_in;
   logic              last_ff, last_in;

   logic              accept;
   logic [CNT_W+11:0] ang_prod;
   logic [15:0]       ang_now;
   logic [15:0]       spd_raw;
   logic [16:0]       spd_abs;
   logic [15:0]       diff;
   logic [16:0]       mag;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;

   assign ang_prod = (CNT_W+12)'(count_ff) * (CNT_W+12)'(cfg.angle_step);
   assign ang_now  = 16'(cfg.angle_start) + ang_prod[15:0];
   assign spd_raw  = 16'(req_data.speed_mm_s);
   assign spd_abs  = spd_raw[15] ? 17'(17'h10000 - {1'b0, spd_raw}) : {1'b0, spd_raw};

   assign diff = angle_ff - scan_steer_ff;
   assign mag  = diff[15] ? 17'(17'h10000 - {1'b0, diff}) : {1'b0, diff};

   always_comb begin
      state_in      = state_ff;
      held_speed_in = held_speed_ff;
      held_steer_in = held_steer_ff;
      scan_speed_in = scan_speed_ff;
      scan_steer_in = scan_steer_ff;
      count_in      = count_ff;
      angle_in      = angle_ff;
      rng_ok_in     = rng_ok_ff;
      range_in      = range_ff;
      last_in       = last_ff;
      push          = 1'b0;
      push_data.keep  = rng_ok_ff && (mag <= 17'(cfg.angle_window));
      push_data.last  = last_ff;
      push_data.range = range_ff;
      push_data.speed = scan_speed_ff;
      push_data.angle = angle_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_SPEED: held_speed_in = spd_abs;
                  OP_STEER: held_steer_in = 16'(req_data.steer_angle);
                  OP_BEAM: begin
                     // latch speed and steering at the first beam of a scan
                     if (count_ff == '0) begin
                        scan_speed_in = held_speed_ff;
                        scan_steer_in = held_steer_ff;
                     end
                     angle_in  = ang_now;
                     range_in  = req_data.beam_range_mm;
                     last_in   = req_data.last_beam;
                     rng_ok_in = req_data.range_is_number
                              && (req_data.beam_range_mm >= cfg.range_floor_mm)
                              && (req_data.beam_range_mm <= cfg.range_ceiling_mm);
                     if (req_data.last_beam) begin
                        count_in = '0;
                     end else if (count_ff != CNT_LAST) begin
                        count_in = count_ff + 1'b1;
                     end
                     state_in = F_BEAM;
                  end
                  default: ;
               endcase
            end
         end
         F_BEAM: begin
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         held_speed_ff <= '0;
         held_steer_ff <= '0;
         scan_speed_ff <= '0;
         scan_steer_ff <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         held_speed_ff <= held_speed_in;
         held_steer_ff <= held_steer_in;
         scan_speed_ff <= scan_speed_in;
         scan_steer_ff <= scan_steer_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff  <= angle_in;
      rng_ok_ff <= rng_ok_in;
      range_ff  <= range_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

### rtl/lstc_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none

module lstc_queue import lstc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   input  wire logic    pop,
   output job_type      head,
   output q_status_type status
);

   job_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue pushed while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/lstc_back.sv
// Back end: cosine lookup, closing speed, TTC divide, scan minima and result register.
`default_nettype none

module lstc_back import lstc_pkg::*; #(
   parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire q_status_type q_status,
   input  wire job_type      head,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type           rsp_data
);

   localparam int IDX_W = $clog2(COS_TABLE_ENTRIES);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_ROM  = 3'd1;
   localparam logic [2:0] B_MUL  = 3'd2;
   localparam logic [2:0] B_CHK  = 3'd3;
   localparam logic [2:0] B_DIV  = 3'd4;
   localparam logic [2:0] B_DONE = 3'd5;

   logic signed [15:0] rom_w [COS_TABLE_ENTRIES];

   for (genvar k = 0; k < COS_TABLE_ENTRIES; k++) begin : g_rom
      assign rom_w[k] = cos_entry(k, IDX_W);
   end

   logic [2:0]         state_ff, state_in;
   job_type            job_ff, job_in;
   logic signed [15:0] cos_ff;
   logic signed [30:0] closing_ff, closing_in;
   logic [39:0]        num_ff, num_in;
   logic [29:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic               ttc_hit_ff, ttc_hit_in;
   logic [15:0]        best_dist_ff, best_dist_in;
   logic               any_dist_ff, any_dist_in;
   logic [15:0]        best_ttc_ff, best_ttc_in;
   logic               any_ttc_ff, any_ttc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]   cos_idx;
   logic signed [33:0] prod;
   logic               closing_gt;
   logic [29:0]        divisor;
   logic [30:0]        trial;
   logic               trial_ge;
   logic [15:0]        ttc_best_m;
   logic               ttc_any_m;
   logic               out_free;

   assign cos_idx = job_ff.angle[15 -: IDX_W];
   assign prod    = 34'($signed({1'b0, job_ff.speed})) * 34'(cos_ff);
   assign divisor = closing_ff[29:0];
   assign closing_gt = $signed({closing_ff[30], closing_ff})
                     > $signed({2'b00, cfg.closing_floor_mm_s, 14'b0});
   assign trial    = {rem_ff, num_ff[15]};
   assign trial_ge = trial >= {1'b0, divisor};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // merge this beam's TTC into the scan minimum
   always_comb begin
      ttc_best_m = best_ttc_ff;
      ttc_any_m  = any_ttc_ff;
      if (ttc_hit_ff) begin
         if (!any_ttc_ff || quo_ff < best_ttc_ff) begin
            ttc_best_m = quo_ff;
         end
         ttc_any_m = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      closing_in   = closing_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_cnt_in   = bit_cnt_ff;
      ttc_hit_in   = ttc_hit_ff;
      best_dist_in = best_dist_ff;
      any_dist_in  = any_dist_ff;
      best_ttc_in  = best_ttc_ff;
      any_ttc_in   = any_ttc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               job_in   = head;
               state_in = B_ROM;
            end
         end
         B_ROM: state_in = B_MUL;
         B_MUL: begin
            closing_in = $signed(prod[30:0]);
            num_in     = 40'(job_ff.range) * 40'(TTC_SCALE);
            state_in   = B_CHK;
         end
         B_CHK: begin
            ttc_hit_in = 1'b0;
            state_in   = B_DONE;
            if (job_ff.keep) begin
               if (!any_dist_ff || job_ff.range < best_dist_ff) begin
                  best_dist_in = job_ff.range;
               end
               any_dist_in = 1'b1;
               if (closing_gt) begin
                  ttc_hit_in = 1'b1;
                  if (30'(num_ff[39:16]) >= divisor) begin
                     // quotient would not fit: saturate
                     quo_in = 16'hFFFF;
                  end else begin
                     rem_in     = 30'(num_ff[39:16]);
                     quo_in     = '0;
                     bit_cnt_in = '0;
                     state_in   = B_DIV;
                  end
               end
            end
         end
         B_DIV: begin
            rem_in     = trial_ge ? 30'(trial - {1'b0, divisor}) : trial[29:0];
            quo_in     = {quo_ff[14:0], trial_ge};
            num_in     = {num_ff[39:16], num_ff[14:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == 4'hF) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!job_ff.last) begin
               best_ttc_in = ttc_best_m;
               any_ttc_in  = ttc_any_m;
               ttc_hit_in  = 1'b0;
               state_in    = B_IDLE;
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.min_distance_mm = best_dist_ff;
               rsp_data_in.distance_found  = any_dist_ff;
               rsp_data_in.min_ttc_ms      = ttc_best_m;
               rsp_data_in.ttc_found       = ttc_any_m;
               best_dist_in = 16'hFFFF;
               any_dist_in  = 1'b0;
               best_ttc_in  = 16'hFFFF;
               any_ttc_in   = 1'b0;
               ttc_hit_in   = 1'b0;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         ttc_hit_ff   <= 1'b0;
         best_dist_ff <= 16'hFFFF;
         any_dist_ff  <= 1'b0;
         best_ttc_ff  <= 16'hFFFF;
         any_ttc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ttc_hit_ff   <= ttc_hit_in;
         best_dist_ff <= best_dist_in;
         any_dist_ff  <= any_dist_in;
         best_ttc_ff  <= best_ttc_in;
         any_ttc_ff   <= any_ttc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      cos_ff      <= rom_w[cos_idx];
      closing_ff  <= closing_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      bit_cnt_ff  <= bit_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

   a_dist_idle_value: assert property (@(posedge clock) disable iff (reset)
      !any_dist_ff |-> (best_dist_ff == 16'hFFFF))
      else $error("distance minimum set without a kept beam");

endmodule

`default_nettype wire

### rtl/lidar_sector_min_ttc_core.sv
// Top level of the lidar sector minimum distance and time-to-collision monitor.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | req_type: op, speed, steering, beam sample
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_type: scan minima, found flags
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// Speed and steering updates leave the front end idle; a beam holds it until the queue has room.
// Back end per beam: ROM, MUL, CHK, DONE; closing TTCs that fit add a 16-step divide.
// A 4-entry queue lets the front keep accepting while the back works or rsp_ stalls.
// Synchronous reset clears control state and loads register defaults; no clearing pass.
// csr_ready is always high.
`default_nettype none

module lidar_sector_min_ttc_core import lstc_pkg::*; #(
   parameter int MAX_BEAMS         = MAX_BEAMS_DEFAULT,
   parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   logic         push;
   job_type      push_data;
   logic         pop;
   job_type      head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RANGE_FLOOR:   cfg_in.range_floor_mm     = csr_wdata;
            CSR_RANGE_CEILING: cfg_in.range_ceiling_mm   = csr_wdata;
            CSR_ANGLE_START:   cfg_in.angle_start        = $signed(csr_wdata);
            CSR_ANGLE_STEP:    cfg_in.angle_step         = csr_wdata[11:0];
            CSR_ANGLE_WINDOW:  cfg_in.angle_window       = csr_wdata[14:0];
            CSR_CLOSING_FLOOR: cfg_in.closing_floor_mm_s = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_floor_mm     <= RST_RANGE_FLOOR;
         cfg_ff.range_ceiling_mm   <= RST_RANGE_CEILING;
         cfg_ff.angle_start        <= $signed(RST_ANGLE_START);
         cfg_ff.angle_step         <= RST_ANGLE_STEP;
         cfg_ff.angle_window       <= RST_ANGLE_WINDOW;
         cfg_ff.closing_floor_mm_s <= RST_CLOSING_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lstc_front #(
      .MAX_BEAMS (MAX_BEAMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   lstc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   lstc_back #(
      .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/sv/lstc_checker.sv
// Scoreboard for the lidar sector TTC monitor: predicts scan minima and compares results.
module lstc_checker import lstc_pkg::*; #(
   parameter int MAX_BEAMS         = MAX_BEAMS_DEFAULT,
   parameter int COS_TABLE_ENTRIES = COS_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = $clog2(MAX_BEAMS);

   int               cos_lut [COS_TABLE_ENTRIES];
   cfg_type          regs;
   logic [16:0]      held_spd;
   logic [16:0]      scan_spd;
   logic [15:0]      held_str;
   logic [15:0]      scan_str;
   logic [IDX_W-1:0] beam_idx;
   logic [15:0]      near_mm;
   logic [15:0]      soon_ms;
   logic             near_seen;
   logic             soon_seen;
   rsp_type          scan_minima_q [$];
   int               fails = 0;
   int               shown = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic longint taylor_div(input int i);
      case (i)
         0:       return 132;
         1:       return 90;
         2:       return 56;
         3:       return 30;
         4:       return 12;
         default: return 2;
      endcase
   endfunction

   // Q14 cosine of r, where 16384 is a quarter turn; nested Horner form of the series
   function automatic int first_quadrant_cos(input longint r);
      longint x;
      longint x2;
      longint t;
      int     i;
      x  = (r * HALF_PI_Q30) >>> 14;
      x2 = (x * x) >>> 30;
      t  = Q30_ONE;
      for (i = 0; i < 6; i++) begin
         t = Q30_ONE - ((x2 * t) >>> 30) / taylor_div(i);
         if (t < 0) t = 0;
         if (t > Q30_ONE) t = Q30_ONE;
      end
      return int'((t + 32768) >>> 16);
   endfunction

   initial begin
      longint a;
      longint q;
      longint r;
      for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
         a = ((longint'(k) * 65536) / COS_TABLE_ENTRIES) & 64'hFFFF;
         q = a >>> 14;
         r = a & 64'h3FFF;
         case (q)
            0:       cos_lut[k] = first_quadrant_cos(r);
            1:       cos_lut[k] = -first_quadrant_cos(16384 - r);
            2:       cos_lut[k] = -first_quadrant_cos(r);
            default: cos_lut[k] = first_quadrant_cos(16384 - r);
         endcase
      end
   end

   task automatic clear_minima();
      beam_idx  = '0;
      near_mm   = '1;
      near_seen = 1'b0;
      soon_ms   = '1;
      soon_seen = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      case (idx)
         CSR_RANGE_FLOOR:   regs.range_floor_mm     = data;
         CSR_RANGE_CEILING: regs.range_ceiling_mm   = data;
         CSR_ANGLE_START:   regs.angle_start        = data;
         CSR_ANGLE_STEP:    regs.angle_step         = data[11:0];
         CSR_ANGLE_WINDOW:  regs.angle_window       = data[14:0];
         CSR_CLOSING_FLOOR: regs.closing_floor_mm_s = data;
         default: ;
      endcase
   endtask

   task automatic take_beam(input req_type it);
      int unsigned sum;
      logic [15:0] ang;
      logic [15:0] dif;
      logic [16:0] mag;
      longint      lut_i;
      longint      closing;
      longint      ttc;
      rsp_type     res;
      // latch motion state on the first beam of the scan
      if (beam_idx == 0) begin
         scan_spd = held_spd;
         scan_str = held_str;
      end
      sum = {16'd0, regs.angle_start} + beam_idx * regs.angle_step;
      ang = sum[15:0];
      dif = ang - scan_str;
      mag = dif[15] ? (17'h10000 - {1'b0, dif}) : {1'b0, dif};
      if (it.range_is_number && it.beam_range_mm >= regs.range_floor_mm &&
          it.beam_range_mm <= regs.range_ceiling_mm && mag <= {2'b00, regs.angle_window}) begin
         lut_i   = (longint'(ang) * COS_TABLE_ENTRIES) >>> 16;
         closing = longint'(scan_spd) * longint'(cos_lut[lut_i]);
         if (!near_seen || it.beam_range_mm < near_mm) near_mm = it.beam_range_mm;
         near_seen = 1'b1;
         if (closing > longint'(regs.closing_floor_mm_s) * 16384) begin
            ttc = (longint'(it.beam_range_mm) * longint'(TTC_SCALE)) / closing;
            if (ttc > 65535) ttc = 65535;
            if (!soon_seen || ttc < longint'(soon_ms)) soon_ms = 16'(ttc);
            soon_seen = 1'b1;
         end
      end
      if (!it.last_beam) begin
         // hold the index at the top once the scan runs long
         if (beam_idx < MAX_BEAMS - 1) beam_idx = beam_idx + 1'b1;
      end else begin
         res.min_distance_mm = near_mm;
         res.distance_found  = near_seen;
         res.min_ttc_ms      = soon_ms;
         res.ttc_found       = soon_seen;
         scan_minima_q.push_back(res);
         clear_minima();
      end
   endtask

   task automatic take_req(input req_type it);
      logic [15:0] s;
      case (it.op)
         OP_SPEED: begin
            s = it.speed_mm_s;
            held_spd = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
         end
         OP_STEER: held_str = it.steer_angle;
         OP_BEAM:  take_beam(it);
         default: ;
      endcase
   endtask

   task automatic check_minima(input rsp_type got);
      rsp_type want;
      if (scan_minima_q.size() == 0) begin
         fails++;
         if (shown < 10)
            $display("ERROR: result with no scan pending at %0t: dist %0d/%0b ttc %0d/%0b",
                     $realtime, got.min_distance_mm, got.distance_found,
                     got.min_ttc_ms, got.ttc_found);
         shown++;
      end else begin
         want = scan_minima_q.pop_front();
         if (got.min_distance_mm !== want.min_distance_mm ||
             got.distance_found !== want.distance_found ||
             got.min_ttc_ms !== want.min_ttc_ms || got.ttc_found !== want.ttc_found) begin
            fails++;
            if (shown < 10)
               $display("ERROR: scan minima at %0t: expected dist %0d/%0b ttc %0d/%0b, %s",
                        $realtime, want.min_distance_mm, want.distance_found,
                        want.min_ttc_ms, want.ttc_found,
                        $sformatf("got dist %0d/%0b ttc %0d/%0b", got.min_distance_mm,
                                  got.distance_found, got.min_ttc_ms, got.ttc_found));
            shown++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs.range_floor_mm     = RST_RANGE_FLOOR;
         regs.range_ceiling_mm   = RST_RANGE_CEILING;
         regs.angle_start        = RST_ANGLE_START;
         regs.angle_step         = RST_ANGLE_STEP;
         regs.angle_window       = RST_ANGLE_WINDOW;
         regs.closing_floor_mm_s = RST_CLOSING_FLOOR;
         held_spd = '0;
         held_str = '0;
         scan_spd = '0;
         scan_str = '0;
         clear_minima();
         scan_minima_q.delete();
      end else begin
         if (csr_valid && csr_ready) write_reg(csr_index, csr_wdata);
         // compare the older scan before a same-cycle last beam queues a new one
         if (rsp_valid && !rsp_stall) check_minima(rsp_data);
         if (req_valid && !req_stall) take_req(req_data);
      end
      pending    <= scan_minima_q.size();
      fail_count <= fails;
   end

endmodule

### tb/sv/tb_lidar_sector_min_ttc_core.sv
// Stimulus and verdict for the lidar sector TTC monitor, with the scoreboard beside the core.
module tb_lidar_sector_min_ttc_core;
   import lstc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES   = 150;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int IDLE_HEAVY      = 73;
   localparam int IDLE_LIGHT      = 10;
   localparam int REQ_W           = $bits(req_type);
   localparam logic [1:0]           OP_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;
   int                   err_count;
   int                   scans_left;
   int                   idle_pct  = 0;
   int                   stall_pct = 0;
   cfg_type              live_cfg;

   lidar_sector_min_ttc_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lstc_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (err_count),
      .pending    (scans_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // Unused fields of every item carry random bits.
   function automatic req_type speed_item(input int v);
      logic [REQ_W-1:0] junk;
      req_type it;
      junk = REQ_W'({$urandom(), $urandom()});
      it = junk;
      it.op = OP_SPEED;
      it.speed_mm_s = 16'(v);
      return it;
   endfunction

   function automatic req_type steer_item(input int v);
      logic [REQ_W-1:0] junk;
      req_type it;
      junk = REQ_W'({$urandom(), $urandom()});
      it = junk;
      it.op = OP_STEER;
      it.steer_angle = 16'(v);
      return it;
   endfunction

   function automatic req_type beam_item(input int r, input bit num, input bit last);
      logic [REQ_W-1:0] junk;
      req_type it;
      junk = REQ_W'({$urandom(), $urandom()});
      it = junk;
      it.op = OP_BEAM;
      it.beam_range_mm = 16'(r);
      it.range_is_number = num;
      it.last_beam = last;
      return it;
   endfunction

   task automatic send_req(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Drop valid, wait for every scan result, then let the back end drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scans_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input int f, input int c, input int s, input int st,
                              input int w, input int cf);
      settle();
      write_csr(CSR_RANGE_FLOOR, 16'(f));
      write_csr(CSR_RANGE_CEILING, 16'(c));
      write_csr(CSR_ANGLE_START, 16'(s));
      write_csr(CSR_ANGLE_STEP, {4'($urandom()), 12'(st)});
      write_csr(CSR_ANGLE_WINDOW, {1'($urandom()), 15'(w)});
      write_csr(CSR_CLOSING_FLOOR, 16'(cf));
      csr_valid <= 1'b0;
      live_cfg.range_floor_mm     = 16'(f);
      live_cfg.range_ceiling_mm   = 16'(c);
      live_cfg.angle_start        = 16'(s);
      live_cfg.angle_step         = 12'(st);
      live_cfg.angle_window       = 15'(w);
      live_cfg.closing_floor_mm_s = 16'(cf);
   endtask

   // Mostly well-formed scans with random content; the rest is noise and stray beams.
   task automatic random_traffic(input int n);
      logic [REQ_W-1:0] junk;
      req_type noise;
      int sent;
      int beams;
      int base;
      int off;
      int w;
      int lo;
      int hi;
      int r;
      int v;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(0, 9) == 0) begin
            junk = REQ_W'({$urandom(), $urandom()});
            noise = junk;
            send_req(noise);
            if (noise.op != OP_UNUSED) sent++;
         end else begin
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 3))
                  0:       v = $urandom_range(0, 65535);
                  1:       v = int'($urandom_range(0, 600)) - 300;
                  2:       v = ($urandom_range(0, 1) == 1) ? -32768 : 32767;
                  default: v = int'($urandom_range(1000, 32767)) *
                               (($urandom_range(0, 1) == 1) ? -1 : 1);
               endcase
               send_req(speed_item(v));
               sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
               if ($urandom_range(0, 3) != 0) begin
                  // aim near the first beams so the window test goes both ways
                  base = int'(live_cfg.angle_start) +
                         int'($urandom_range(0, 10)) * int'(live_cfg.angle_step);
                  w    = int'(live_cfg.angle_window);
                  off  = int'($urandom_range(0, 2 * w + 40)) - (w + 20);
                  v    = base + off;
               end else begin
                  v = $urandom_range(0, 65535);
               end
               send_req(steer_item(v));
               sent++;
            end
            beams = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            lo = (live_cfg.range_floor_mm < live_cfg.range_ceiling_mm) ?
                 int'(live_cfg.range_floor_mm) : int'(live_cfg.range_ceiling_mm);
            hi = (live_cfg.range_floor_mm < live_cfg.range_ceiling_mm) ?
                 int'(live_cfg.range_ceiling_mm) : int'(live_cfg.range_floor_mm);
            for (int k = 0; k < beams; k++) begin
               case ($urandom_range(0, 3))
                  0:       r = $urandom_range(0, 65535);
                  1:       r = $urandom_range((lo > 4) ? lo - 4 : 0,
                                              (lo + 40 > 65535) ? 65535 : lo + 40);
                  2:       r = $urandom_range((hi > 40) ? hi - 40 : 0,
                                              (hi + 4 > 65535) ? 65535 : hi + 4);
                  default: r = $urandom_range(lo, hi);
               endcase
               send_req(beam_item(r, $urandom_range(0, 7) != 0, k == beams - 1));
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [REQ_W-1:0] ones;
      int p;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      live_cfg.range_floor_mm     = RST_RANGE_FLOOR;
      live_cfg.range_ceiling_mm   = RST_RANGE_CEILING;
      live_cfg.angle_start        = RST_ANGLE_START;
      live_cfg.angle_step         = RST_ANGLE_STEP;
      live_cfg.angle_window       = RST_ANGLE_WINDOW;
      live_cfg.closing_floor_mm_s = RST_CLOSING_FLOOR;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // an index past the register file must change nothing
      write_csr(CSR_IDX_SPARE, 16'hFFFF);
      csr_valid <= 1'b0;

      // Reset settings: beams point backward, so nothing closes.
      send_req(speed_item(-32768));
      send_req(steer_item(int'(RST_ANGLE_START)));
      ones = '1;
      send_req(ones);
      send_req(beam_item(59, 1'b1, 1'b0));
      send_req(beam_item(60, 1'b1, 1'b0));
      send_req(beam_item(30001, 1'b1, 1'b0));
      send_req(beam_item(30000, 1'b1, 1'b0));
      send_req(beam_item(100, 1'b0, 1'b0));
      send_req(beam_item(65535, 1'b1, 1'b1));
      send_req(beam_item(0, 1'b0, 1'b1));

      // Forward-facing sector: closing beams, zero speed, TTC saturation, floor tie.
      load_config(60, 30000, 0, 45, 4172, 1);
      send_req(speed_item(32767));
      send_req(steer_item(0));
      send_req(beam_item(1000, 1'b1, 1'b0));
      send_req(beam_item(65535, 1'b0, 1'b1));
      send_req(speed_item(0));
      send_req(beam_item(500, 1'b1, 1'b1));
      send_req(speed_item(2));
      send_req(beam_item(200, 1'b1, 1'b1));
      send_req(speed_item(1));
      send_req(beam_item(300, 1'b1, 1'b1));
      send_req(steer_item(32767));
      send_req(beam_item(100, 1'b1, 1'b1));

      // Widest settings: half-turn difference is out, full-scale range is kept.
      load_config(0, 65535, -32768, 4095, 32767, 0);
      send_req(steer_item(0));
      send_req(beam_item(65535, 1'b1, 1'b0));
      send_req(beam_item(65535, 1'b1, 1'b1));

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;          stall_pct = 0;          end
            1: begin idle_pct = IDLE_HEAVY; stall_pct = 0;          end
            2: begin idle_pct = 0;          stall_pct = IDLE_HEAVY; end
            default: begin idle_pct = IDLE_LIGHT; stall_pct = IDLE_LIGHT; end
         endcase
         case (p)
            0: load_config(60, 30000, 0, 45, 4172, 1);
            1: load_config(0, 65535, -32768, 4095, 32767, 0);
            2: load_config(65535, 65535, 16000, 1, 100, 65535);
            3: load_config(1000, 500, 0, 100, 8000, 10);
            4: load_config(100, 20000, -2000, 0, 0, 500);
            default: load_config($urandom_range(0, 2000), $urandom_range(1000, 65535),
                                 ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) :
                                    int'($urandom_range(0, 16000)) - 8000,
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) :
                                    $urandom_range(0, 200),
                                 $urandom_range(0, 32767), $urandom_range(0, 3000));
         endcase
         random_traffic(ITEMS_PER_PHASE);
      end

      settle();
      if (err_count == 0 && scans_left == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### lidar_sector_min_ttc_core.f
rtl/lstc_pkg.sv
rtl/lstc_front.sv
rtl/lstc_queue.sv
rtl/lstc_back.sv
rtl/lidar_sector_min_ttc_core.sv
tb/sv/lstc_checker.sv
tb/sv/tb_lidar_sector_min_ttc_core.sv
